// File: hdl/fan_pwm_demand_arbiter_macros.svh
// ----------------------------------------------------------------------------
// fan_pwm_demand_arbiter_macros.svh
// assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef FAN_PWM_DEMAND_ARBITER_MACROS_SVH
`define FAN_PWM_DEMAND_ARBITER_MACROS_SVH

// same-cycle implication under reset
`define FPDA_ASSERT_IMPLY(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("fpda assertion failed");

// next-cycle implication under reset
`define FPDA_ASSERT_NEXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("fpda assertion failed");

`endif

// File: hdl/fpda_pkg.sv
// ----------------------------------------------------------------------------
// fpda_pkg
// types and constants of the fan drive demand arbiter
// ----------------------------------------------------------------------------
package fpda_pkg;

	localparam int NUM_SOURCES_DEF = 8;
	localparam int PWM_FULL_DEF    = 255;
	localparam int CFG_IDX_W       = 4;

	// register indexes of the configuration port
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MIN_PWM         = 4'd0,
		CFG_MAX_PWM         = 4'd1,
		CFG_STOP_ENABLE     = 4'd2,
		CFG_STOP_HYSTERESIS = 4'd3
	} cfg_idx_t;

	// item kinds
	typedef enum logic {
		KIND_DEMAND = 1'b0,
		KIND_CLEAR  = 1'b1
	} kind_t;

	// fan events
	typedef enum logic [1:0] {
		EV_NONE  = 2'd0,
		EV_STOP  = 2'd1,
		EV_START = 2'd2
	} fan_event_t;

	// last written value before anything was written
	localparam logic [8:0] LAST_NONE = 9'd511;

	// half of 100 percent in Q8.8, for rounding
	localparam int ROUND_HALF = 12800;

	typedef struct packed {
		kind_t              kind;
		logic [2:0]         source_index;
		logic signed [15:0] demand;
		logic signed [7:0]  temp_offset;
	} item_t;

	typedef struct packed {
		logic [7:0] pwm_value;
		logic       pwm_write;
		fan_event_t fan_event;
	} result_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0] index;
		logic [7:0]           value;
	} cfg_wr_t;

	// control from the sequencer to the demand store
	typedef struct packed {
		logic               wr_en;
		logic               clr;
		logic [2:0]         addr;
		logic signed [15:0] data;
		logic               scan_start;
	} store_ctrl_t;

	// status from the demand store
	typedef struct packed {
		logic               done;
		logic               any;
		logic signed [15:0] best;
	} store_stat_t;

endpackage

// File: hdl/fpda_chan_if.sv
// ----------------------------------------------------------------------------
// fpda_chan_if
// valid/ready channel carrying one payload item
// ----------------------------------------------------------------------------
interface fpda_chan_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: hdl/fpda_store.sv
// ----------------------------------------------------------------------------
// fpda_store
// demand memory with valid bits and a one-read-per-cycle maximum scan
// ----------------------------------------------------------------------------
module fpda_store #(
	parameter int NUM_SOURCES = fpda_pkg::NUM_SOURCES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  fpda_pkg::store_ctrl_t ctrl,
	output fpda_pkg::store_stat_t stat
);
	localparam int AW = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
	localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_SOURCES - 1);

	logic signed [15:0]     mem_q [NUM_SOURCES];
	logic [NUM_SOURCES-1:0] valid_q;
	logic                   rd_act_q;
	logic [AW-1:0]          rd_cnt_q;
	logic                   chk_s1;
	logic                   last_s1;
	logic [AW-1:0]          idx_s1;
	logic signed [15:0]     rdata_s1;
	logic                   done_q;
	logic                   any_q;
	logic signed [15:0]     best_q;
	logic                   in_range;
	logic                   take;

	assign in_range = 32'(ctrl.addr) < NUM_SOURCES;

	// candidate beats the running maximum
	assign take = chk_s1 && valid_q[idx_s1] && (!any_q || (rdata_s1 > best_q));

	// memory write port and registered read port
	always_ff @(posedge clk) begin
		if (ctrl.wr_en && in_range) begin
			mem_q[AW'(ctrl.addr)] <= ctrl.data;
		end
		rdata_s1 <= mem_q[rd_cnt_q];
		idx_s1   <= rd_cnt_q;
		if (take) begin
			best_q <= rdata_s1;
		end
	end

	// valid bits and scan control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rd_act_q <= 1'b0;
			rd_cnt_q <= '0;
			chk_s1   <= 1'b0;
			last_s1  <= 1'b0;
			done_q   <= 1'b0;
			any_q    <= 1'b0;
		end else begin
			if (ctrl.clr) begin
				valid_q <= '0;
			end else if (ctrl.wr_en && in_range) begin
				valid_q[AW'(ctrl.addr)] <= 1'b1;
			end
			chk_s1  <= rd_act_q;
			last_s1 <= rd_act_q && (rd_cnt_q == LAST_ADDR);
			done_q  <= chk_s1 && last_s1;
			if (ctrl.scan_start) begin
				rd_act_q <= 1'b1;
				rd_cnt_q <= '0;
				any_q    <= 1'b0;
			end else begin
				if (rd_act_q) begin
					if (rd_cnt_q == LAST_ADDR) begin
						rd_act_q <= 1'b0;
					end else begin
						rd_cnt_q <= rd_cnt_q + AW'(1);
					end
				end
				if (take) begin
					any_q <= 1'b1;
				end
			end
		end
	end

	assign stat.done = done_q;
	assign stat.any  = any_q;
	assign stat.best = best_q;
endmodule

// File: hdl/fpda_scale.sv
// ----------------------------------------------------------------------------
// fpda_scale
// three-stage linear scaling of a demand onto the drive range
// ----------------------------------------------------------------------------
module fpda_scale (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [7:0]         min_pwm,
	input  logic [7:0]         max_pwm,
	input  logic signed [15:0] demand,
	output logic               done,
	output logic [7:0]         value
);
	// 5243 / 2^17 is exact as 1/25 for every quotient in range
	localparam logic [12:0] RECIP_25 = 13'd5243;
	localparam int          RECIP_SH = 17;
	localparam int          ROUND_OFFSET = fpda_pkg::ROUND_HALF;

	logic               v_s1, v_s2, v_s3;
	logic signed [24:0] p_s1;
	logic               neg_s2;
	logic [27:0]        prod_s2;
	logic [7:0]         value_s3;

	logic signed [8:0]  diff;
	logic [23:0]        mag;
	logic [24:0]        biased;
	logic [14:0]        y;
	logic [9:0]         q;
	logic signed [10:0] r;
	logic signed [10:0] v;
	logic signed [10:0] hi;
	logic [7:0]         sat;

	// stage 1 operands
	assign diff = $signed({1'b0, max_pwm}) - $signed({1'b0, min_pwm});

	// stage 2: magnitude, rounding bias, divide by 1024
	assign mag    = p_s1[24] ? 24'(-p_s1) : 24'(p_s1);
	assign biased = {1'b0, mag} + 25'(ROUND_OFFSET);
	assign y      = biased[24:10];

	// stage 3: divide by 25, sign, offset and saturate
	assign q  = prod_s2[RECIP_SH +: 10];
	assign r  = neg_s2 ? -$signed({1'b0, q}) : $signed({1'b0, q});
	assign v  = $signed({3'b000, min_pwm}) + r;
	assign hi = $signed({3'b000, max_pwm});
	always_comb begin
		sat = v[7:0];
		if (max_pwm >= min_pwm) begin
			if (v > hi) sat = max_pwm;
		end else begin
			if (v < hi) sat = max_pwm;
		end
	end

	always_ff @(posedge clk) begin
		p_s1     <= diff * demand;
		neg_s2   <= p_s1[24];
		prod_s2  <= 28'(y) * 28'(RECIP_25);
		value_s3 <= sat;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	assign done  = v_s3;
	assign value = value_s3;
endmodule

// File: hdl/fan_pwm_demand_arbiter.sv
// ----------------------------------------------------------------------------
// fan_pwm_demand_arbiter
// stores fan demands per source, drives the fan from the largest one
//
//   channel  role   payload                                      handshake
//   req      sink   kind, source_index, demand, temp_offset      valid/ready
//   rsp      source pwm_value, pwm_write, fan_event              valid/ready
//   cfg      sink   index, value (min, max, stop enable, hyst)   valid/ready
//
// a demand item passes through the scan that reads the demand memory one
// entry per cycle, followed by the three-stage scaler; a clear item goes
// straight from acceptance to the result register.
// one item at a time; the next is taken while a result waits in rsp.
// reset clears valid bits, stop flag and last value; memory stays unwritten.
// ----------------------------------------------------------------------------
module fan_pwm_demand_arbiter #(
	parameter int NUM_SOURCES = fpda_pkg::NUM_SOURCES_DEF,
	parameter int PWM_FULL    = fpda_pkg::PWM_FULL_DEF
) (
	input logic         clk,
	input logic         arst_n,
	fpda_chan_if.sink   req,
	fpda_chan_if.source rsp,
	fpda_chan_if.sink   cfg
);
	localparam logic [7:0] MAX_RST = (PWM_FULL > 255) ? 8'd255 : 8'(PWM_FULL);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SCALE,
		ST_DONE
	} state_t;

	state_t                state_q;
	fpda_pkg::item_t       item_q;
	fpda_pkg::item_t       req_item;
	fpda_pkg::cfg_wr_t     cfg_wr;
	fpda_pkg::result_t     rsp_data_q;
	fpda_pkg::result_t     res_d;
	logic                  rsp_valid_q;
	logic                  rsp_load;
	logic                  stopped_q;
	logic                  stop_d;
	logic [8:0]            last_q;
	logic [7:0]            raw;
	logic [7:0]            neg_t;
	logic                  req_acc;

	logic [7:0]            min_pwm_q;
	logic [7:0]            max_pwm_q;
	logic                  stop_en_q;
	logic [6:0]            hyst_q;

	fpda_pkg::store_ctrl_t st_ctrl;
	fpda_pkg::store_stat_t st_stat;
	logic                  sc_start;
	logic                  sc_done;
	logic [7:0]            sc_value;

	assign req_item  = req.data;
	assign cfg_wr    = cfg.data;
	assign req.ready = (state_q == ST_IDLE);
	assign req_acc   = req.valid && req.ready;
	assign cfg.ready = 1'b1;

	// result register takes a new item when empty or drained this cycle
	assign rsp_load = (state_q == ST_DONE) && (!rsp_valid_q || rsp.ready);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_pwm_q <= 8'd0;
			max_pwm_q <= MAX_RST;
			stop_en_q <= 1'b0;
			hyst_q    <= 7'd0;
		end else if (cfg.valid) begin
			unique case (cfg_wr.index)
				fpda_pkg::CFG_MIN_PWM:         min_pwm_q <= cfg_wr.value;
				fpda_pkg::CFG_MAX_PWM:         max_pwm_q <= cfg_wr.value;
				fpda_pkg::CFG_STOP_ENABLE:     stop_en_q <= cfg_wr.value[0];
				fpda_pkg::CFG_STOP_HYSTERESIS: hyst_q    <= cfg_wr.value[6:0];
				default: ;
			endcase
		end
	end

	// store access: write or clear at acceptance; a write also starts the scan
	always_comb begin
		st_ctrl.wr_en      = req_acc && (req_item.kind == fpda_pkg::KIND_DEMAND);
		st_ctrl.clr        = req_acc && (req_item.kind == fpda_pkg::KIND_CLEAR);
		st_ctrl.addr       = req_item.source_index;
		st_ctrl.data       = req_item.demand;
		st_ctrl.scan_start = st_ctrl.wr_en;
	end

	fpda_store #(
		.NUM_SOURCES(NUM_SOURCES)
	) u_store (
		.clk   (clk),
		.arst_n(arst_n),
		.ctrl  (st_ctrl),
		.stat  (st_stat)
	);

	assign sc_start = (state_q == ST_SCAN) && st_stat.done;

	fpda_scale u_scale (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sc_start),
		.min_pwm(min_pwm_q),
		.max_pwm(max_pwm_q),
		.demand (st_stat.best),
		.done   (sc_done),
		.value  (sc_value)
	);

	// stop rule with hysteresis
	assign neg_t = 8'(~item_q.temp_offset) + 8'd1;
	always_comb begin
		stop_d = stopped_q;
		if (stop_en_q) begin
			if (!item_q.temp_offset[7]) begin
				stop_d = 1'b0;
			end else if (neg_t >= {1'b0, hyst_q}) begin
				stop_d = 1'b1;
			end
		end
	end

	// drive value and change events
	always_comb begin
		raw = (stop_en_q && stop_d) ? 8'd0 : min_pwm_q;
		if (st_stat.any && !st_stat.best[15]) begin
			raw = sc_value;
		end
		res_d.pwm_value = raw;
		res_d.pwm_write = ({1'b0, raw} != last_q);
		res_d.fan_event = fpda_pkg::EV_NONE;
		if (item_q.kind == fpda_pkg::KIND_CLEAR) begin
			res_d.pwm_value = (last_q == fpda_pkg::LAST_NONE) ? 8'd0 : last_q[7:0];
			res_d.pwm_write = 1'b0;
		end else if (res_d.pwm_write) begin
			priority if (raw == 8'd0) begin
				res_d.fan_event = fpda_pkg::EV_STOP;
			end else if (last_q == 9'd0) begin
				res_d.fan_event = fpda_pkg::EV_START;
			end else begin
				res_d.fan_event = fpda_pkg::EV_NONE;
			end
		end
	end

	// item payload
	always_ff @(posedge clk) begin
		if (req_acc) begin
			item_q <= req_item;
		end
	end

	// sequencer, result register and drive state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
			rsp_data_q  <= '0;
			stopped_q   <= 1'b0;
			last_q      <= fpda_pkg::LAST_NONE;
		end else begin
			if (rsp.ready && !rsp_load) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req_acc) begin
						state_q <= (req_item.kind == fpda_pkg::KIND_CLEAR) ? ST_DONE : ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (st_stat.done) state_q <= ST_SCALE;
				end
				ST_SCALE: begin
					if (sc_done) state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (rsp_load) begin
						rsp_valid_q <= 1'b1;
						rsp_data_q  <= res_d;
						if (item_q.kind == fpda_pkg::KIND_DEMAND) begin
							stopped_q <= stop_d;
							if (res_d.pwm_write) last_q <= {1'b0, raw};
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_data_q;
endmodule

// File: hdl/fpda_checker.sv
// ----------------------------------------------------------------------------
// fpda_checker
// port-level checks of the fan drive demand arbiter, bound to the top level
// ----------------------------------------------------------------------------
`include "fan_pwm_demand_arbiter_macros.svh"

module fpda_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       req_valid,
	input logic       req_ready,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic [7:0] pwm_value,
	input logic       pwm_write,
	input logic [1:0] fan_event
);
	logic req_acc;
	assign req_acc = req_valid && req_ready;

	// an event only comes with a write
	`FPDA_ASSERT_IMPLY(a_event_needs_write, clk, arst_n, rsp_valid && !pwm_write, fan_event == fpda_pkg::EV_NONE)

	// a stop event drives zero
	`FPDA_ASSERT_IMPLY(a_stop_is_zero, clk, arst_n, rsp_valid && (fan_event == fpda_pkg::EV_STOP), pwm_value == 8'd0)

	// a start event drives a nonzero value
	`FPDA_ASSERT_IMPLY(a_start_nonzero, clk, arst_n, rsp_valid && (fan_event == fpda_pkg::EV_START), pwm_value != 8'd0)

	// one item in work at a time
	`FPDA_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, req_acc, !req_ready)

	// a stalled result holds
	`FPDA_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(pwm_value) && $stable(pwm_write) && $stable(fan_event))
endmodule

bind fan_pwm_demand_arbiter fpda_checker u_fpda_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.req_valid(req.valid),
	.req_ready(req.ready),
	.rsp_valid(rsp.valid),
	.rsp_ready(rsp.ready),
	.pwm_value(rsp.data.pwm_value),
	.pwm_write(rsp.data.pwm_write),
	.fan_event(rsp.data.fan_event)
);
